### rtl/core/ascii_command_line_parser_defines.svh
// Assertion macros shared by the command line parser modules
`ifndef ASCII_COMMAND_LINE_PARSER_DEFINES_SVH
`define ASCII_COMMAND_LINE_PARSER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define ACLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ACLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/aclp_pkg.sv
// Types, codes and character constants of the command line parser
package aclp_pkg;

  // Characters of interest
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result item kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Line status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_HASH   = 3'd1;
  localparam logic [2:0] STAT_EMPTY_KEY = 3'd2;
  localparam logic [2:0] STAT_NO_DATA   = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

  // Output beat layout
  localparam int OUT_W = 16;

  // Verdict on a finished line
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_OVERFLOW,
    JOB_NO_HASH,
    JOB_EMPTY_KEY,
    JOB_NO_DATA,
    JOB_EMIT
  } aclp_job_e;

  typedef struct packed {
    logic      go;
    aclp_job_e code;
  } aclp_job_t;

  // Emitter states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_STAT
  } aclp_state_e;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### rtl/core/aclp_line_ram.sv
// Line store: one write port, one registered read port
module aclp_line_ram import aclp_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write the stored character
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: the data follows the address in the next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/aclp_line_scan.sv
// Line assembly: stores bytes and tracks hash, colon, key and trim marks
module aclp_line_scan import aclp_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int KEY_BYTES   = 16,
  parameter int IW          = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          burst_end,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output aclp_job_t     job,
  output logic [IW-1:0] key_last,
  output logic [IW-1:0] colon_pos,
  output logic [IW-1:0] last_nb
);

  `include "ascii_command_line_parser_defines.svh"

  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);

  logic          ovf, hash_ok, any_nb, colon_seen;
  logic [IW-1:0] len, cur_last_nb, cur_colon, cur_key;

  logic          delim, blank, store_ok, finish;
  logic          ovf_u, hash_u, any_nb_u, colon_seen_u;
  logic [IW-1:0] len_u, last_nb_u, colon_u, key_u;
  aclp_job_e     code_u;

  // Apply the byte to the line marks
  always_comb begin
    delim    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    blank    = is_blank(rx_byte);
    store_ok = !delim && !ovf && (len != LAST_IDX);
    ovf_u    = ovf || (!delim && (len == LAST_IDX));
    len_u    = store_ok ? len + IW'(1) : len;
    hash_u   = (store_ok && (len == '0)) ? (rx_byte == CH_HASH) : hash_ok;
    any_nb_u    = any_nb || (store_ok && !blank);
    last_nb_u   = (store_ok && !blank) ? len : cur_last_nb;
    colon_seen_u = colon_seen;
    colon_u      = cur_colon;
    key_u        = cur_key;
    if (store_ok && !colon_seen && (len != '0)) begin
      if (rx_byte == CH_COLON) begin
        colon_seen_u = 1'b1;
        colon_u      = len;
      end else if (!blank && (32'(len) <= 32'(KEY_BYTES - 1))) begin
        key_u = len;
      end
    end
    finish = delim || burst_end;
  end

  // Judge the line as it stands after this byte
  always_comb begin
    priority if (ovf_u) begin
      code_u = JOB_OVERFLOW;
    end else if (!any_nb_u) begin
      code_u = JOB_NONE;
    end else if (!hash_u) begin
      code_u = JOB_NO_HASH;
    end else if (key_u == '0) begin
      code_u = JOB_EMPTY_KEY;
    end else if (!colon_seen_u || (colon_u == last_nb_u)) begin
      code_u = JOB_NO_DATA;
    end else begin
      code_u = JOB_EMIT;
    end
  end

  assign wr_en   = accept && store_ok;
  assign wr_addr = len;
  assign wr_data = rx_byte;

  // Advance line state, clear it at a line end
  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      ovf        <= 1'b0;
      any_nb     <= 1'b0;
      colon_seen <= 1'b0;
      cur_key    <= '0;
      job.go     <= 1'b0;
      job.code   <= JOB_NONE;
    end else begin
      job.go <= accept && finish;
      if (accept) begin
        if (finish) begin
          len        <= '0;
          ovf        <= 1'b0;
          any_nb     <= 1'b0;
          colon_seen <= 1'b0;
          cur_key    <= '0;
          job.code   <= code_u;
        end else begin
          len        <= len_u;
          ovf        <= ovf_u;
          any_nb     <= any_nb_u;
          colon_seen <= colon_seen_u;
          cur_key    <= key_u;
        end
      end
    end
  end

  // Hold line marks and the snapshot for the emitter
  always_ff @(posedge clk) begin
    if (accept) begin
      hash_ok     <= hash_u;
      cur_last_nb <= last_nb_u;
      cur_colon   <= colon_u;
      if (finish) begin
        key_last  <= key_u;
        colon_pos <= colon_u;
        last_nb   <= last_nb_u;
      end
    end
  end

  `ACLP_ASSERT_NOW(a_ovf_full, ovf, len == LAST_IDX, "overflow mark set below a full line")
  `ACLP_ASSERT_NOW(a_colon_order, colon_seen && any_nb, cur_colon <= cur_last_nb,
                   "colon lies past last nonblank byte")
  `ACLP_ASSERT_NEXT(a_clear_on_end, accept && finish, (len == '0) && !ovf,
                    "line state not cleared at line end")

endmodule

### rtl/core/aclp_emit.sv
// Result sequencer: walks the line store and drives the output register
module aclp_emit import aclp_pkg::*; #(
  parameter int IW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  aclp_job_t        job,
  input  logic [IW-1:0]    key_last,
  input  logic [IW-1:0]    colon_pos,
  input  logic [IW-1:0]    last_nb,
  output logic [IW-1:0]    rd_addr,
  input  logic [7:0]       rd_data,
  output logic             in_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  `include "ascii_command_line_parser_defines.svh"

  aclp_state_e   state, state_next;
  logic [IW-1:0] ptr, ptr_next;
  logic          in_data, in_data_next;
  logic [2:0]    stat_code, stat_code_next;
  logic          slot_free, load, load_last, walk_done;
  logic [OUT_W-1:0] load_data;

  assign slot_free = !m_tvalid || m_tready;
  assign walk_done = in_data && (ptr == last_nb);
  assign in_ready  = (state == ST_IDLE) && !job.go;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (job.go) begin
          unique case (job.code)
            JOB_NONE: state_next = ST_IDLE;
            JOB_EMIT: state_next = ST_READ;
            default:  state_next = ST_STAT;
          endcase
        end
      end
      ST_READ: state_next = ST_PUT;
      ST_PUT: begin
        if (slot_free && walk_done) begin
          state_next = ST_STAT;
        end
      end
      ST_STAT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: pointer walk, read address and output loads
  always_comb begin
    ptr_next       = ptr;
    in_data_next   = in_data;
    stat_code_next = stat_code;
    load           = 1'b0;
    load_last      = 1'b0;
    load_data      = '0;
    unique case (state)
      ST_IDLE: begin
        ptr_next     = IW'(1);
        in_data_next = 1'b0;
        unique case (job.code)
          JOB_OVERFLOW:  stat_code_next = STAT_OVERFLOW;
          JOB_NO_HASH:   stat_code_next = STAT_NO_HASH;
          JOB_EMPTY_KEY: stat_code_next = STAT_EMPTY_KEY;
          JOB_NO_DATA:   stat_code_next = STAT_NO_DATA;
          default:       stat_code_next = STAT_OK;
        endcase
      end
      ST_READ: begin
      end
      ST_PUT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_data = {(OUT_W - 13)'(0), STAT_OK, rd_data,
                       in_data ? KIND_DATA : KIND_KEY};
          if (!in_data && (ptr == key_last)) begin
            ptr_next     = colon_pos + IW'(1);
            in_data_next = 1'b1;
          end else if (!walk_done) begin
            ptr_next = ptr + IW'(1);
          end
        end
      end
      ST_STAT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          load_data = {(OUT_W - 13)'(0), stat_code, 8'h00, KIND_STATUS};
        end
      end
      default: begin
      end
    endcase
    rd_addr = (state == ST_PUT) ? ptr_next : ptr;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    ptr       <= ptr_next;
    in_data   <= in_data_next;
    stat_code <= stat_code_next;
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      m_tdata <= load_data;
      m_tlast <= load_last;
    end
  end

  `ACLP_ASSERT_NOW(a_job_when_idle, job.go, state == ST_IDLE, "line finished while busy")
  `ACLP_ASSERT_NOW(a_last_on_status, m_tvalid, m_tlast == (m_tdata[1:0] == KIND_STATUS),
                   "last flag does not match status beat")
  `ACLP_ASSERT_NOW(a_walk_bound, (state == ST_PUT) && in_data, ptr <= last_nb,
                   "data walk ran past line end")

endmodule

### rtl/core/ascii_command_line_parser.sv
// Top level of the ASCII key/value command line parser
//
// Input beats carry one received byte in s_tdata; s_tlast marks the last byte
// of a reception and flushes any pending line. CR or LF also ends a line.
// A finished line starting with '#' and holding "key:data" yields its key
// bytes, its data bytes and an ok status beat; a bad line yields one error
// status beat; a blank line yields nothing. Status beats carry m_tlast.
// A stored byte does not hold the input; the block stays ready for the next byte.
// A line end passes through the registered job strobe and the idle and read states,
// then gives one result beat per cycle while the receiver takes them, set by the single
// read port of the line store (at most FRAME_BYTES-2 results). No input is taken while a line drains.
// The output register lets the sequencer run one beat ahead of m_tready;
// a stalled receiver holds the walk and the current beat stays on the port.
// Synchronous reset clears the line length, overflow mark and sequencer;
// the line store itself is not cleared.
module ascii_command_line_parser import aclp_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int KEY_BYTES   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  input  logic             s_tlast,   // burst_end
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [1:0] item_kind, [9:2] char_value,
                                      // [12:10] line_status, [15:13] zero
  output logic             m_tlast    // last_of_line
);

  localparam int IW = $clog2(FRAME_BYTES);

  logic          accept;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  aclp_job_t     job;
  logic [IW-1:0] key_last, colon_pos, last_nb;

  assign accept = s_tvalid && s_tready;

  aclp_line_scan #(
    .FRAME_BYTES (FRAME_BYTES),
    .KEY_BYTES   (KEY_BYTES),
    .IW          (IW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .burst_end (s_tlast),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job       (job),
    .key_last  (key_last),
    .colon_pos (colon_pos),
    .last_nb   (last_nb)
  );

  aclp_line_ram #(
    .DEPTH (FRAME_BYTES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aclp_emit #(
    .IW (IW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .key_last  (key_last),
    .colon_pos (colon_pos),
    .last_nb   (last_nb),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### verif/aclp_result_checker.sv
// Checker for the command line parser: predicts result beats and compares them
`timescale 1ns / 100ps

module aclp_result_checker import aclp_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int KEY_BYTES   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  input  logic             s_tlast,   // burst_end
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // [1:0] item_kind, [9:2] char_value,
                                      // [12:10] line_status, [15:13] zero
  input  logic             m_tlast,   // last_of_line
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] status;
    logic       last;
  } parsed_item_t;

  // Shadow copy of the line being collected
  logic [7:0]   line_buf [FRAME_BYTES];
  int           fill;
  bit           too_long;
  parsed_item_t predicted_items [$];

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic put_result(input logic [1:0] k, input logic [7:0] ch,
                            input logic [2:0] st, input logic lst);
    predicted_items.push_back('{k, ch, st, lst});
  endtask

  // Judge a finished line and queue what it yields
  task automatic close_line();
    int n;
    int cut;
    int klen;
    int dstart;
    int i;
    bit found;
    if (too_long) begin
      put_result(KIND_STATUS, 8'h00, STAT_OVERFLOW, 1'b1);
      return;
    end
    n = (fill > FRAME_BYTES - 1) ? FRAME_BYTES - 1 : fill;
    while (n > 0 && blank_char(line_buf[n-1])) n--;
    if (n == 0) return;
    if (line_buf[0] != CH_HASH) begin
      put_result(KIND_STATUS, 8'h00, STAT_NO_HASH, 1'b1);
      return;
    end
    // First colon after the hash splits key from data
    cut = n;
    found = 1'b0;
    for (i = 1; i < n; i++) begin
      if (!found && line_buf[i] == CH_COLON) begin
        cut = i;
        found = 1'b1;
      end
    end
    klen = cut - 1;
    if (klen > KEY_BYTES - 1) klen = KEY_BYTES - 1;
    while (klen > 0 && blank_char(line_buf[klen])) klen--;
    dstart = found ? cut + 1 : n;
    if (klen == 0) begin
      put_result(KIND_STATUS, 8'h00, STAT_EMPTY_KEY, 1'b1);
      return;
    end
    if (!found || dstart >= n) begin
      put_result(KIND_STATUS, 8'h00, STAT_NO_DATA, 1'b1);
      return;
    end
    for (i = 1; i <= klen; i++) put_result(KIND_KEY, line_buf[i], STAT_OK, 1'b0);
    for (i = dstart; i < n; i++) put_result(KIND_DATA, line_buf[i], STAT_OK, 1'b0);
    put_result(KIND_STATUS, 8'h00, STAT_OK, 1'b1);
  endtask

  // Fold one received byte into the line state
  task automatic parse_byte(input logic [7:0] c, input logic burst);
    if (c == CH_CR || c == CH_LF) begin
      close_line();
      fill = 0;
      too_long = 1'b0;
    end else if (!too_long) begin
      if (fill >= FRAME_BYTES - 1) begin
        too_long = 1'b1;
      end else begin
        line_buf[fill] = c;
        fill++;
      end
    end
    if (burst) begin
      if (too_long || fill > 0) close_line();
      fill = 0;
      too_long = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare result beats first, then predict from the input beat
  always @(posedge clk) begin
    parsed_item_t want;
    if (rst) begin
      fill = 0;
      too_long = 1'b0;
      mismatches = 0;
      predicted_items.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_items.size() == 0) begin
          $error("unexpected result beat: tdata=%h tlast=%b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = predicted_items.pop_front();
          check_field("item_kind", 32'(want.kind), 32'(m_tdata[1:0]));
          check_field("char_value", 32'(want.ch), 32'(m_tdata[9:2]));
          check_field("line_status", 32'(want.status), 32'(m_tdata[12:10]));
          check_field("tdata padding", 32'd0, 32'(m_tdata[OUT_W-1:13]));
          check_field("last_of_line", 32'(want.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
    end
    outstanding <= predicted_items.size();
  end

endmodule

### verif/tb_ascii_command_line_parser.sv
// Testbench top for the command line parser: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_ascii_command_line_parser import aclp_pkg::*;;

  localparam int FRAME_BYTES = 32;
  localparam int KEY_BYTES   = 16;
  localparam int BEATS_TOTAL = 460;
  localparam int QUIET_AFTER = 400;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;  // [7:0] rx_byte
  logic             s_tlast = 1'b0;   // burst_end
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;          // [1:0] item_kind, [9:2] char_value,
                                      // [12:10] line_status, [15:13] zero
  logic             m_tlast;          // last_of_line
  int               mismatches;
  int               outstanding;
  int               beats_sent = 0;
  int               cycle_count = 0;
  logic             quiet_phase;

  assign quiet_phase = beats_sent >= QUIET_AFTER;

  ascii_command_line_parser #(
    .FRAME_BYTES(FRAME_BYTES),
    .KEY_BYTES  (KEY_BYTES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  aclp_result_checker #(
    .FRAME_BYTES(FRAME_BYTES),
    .KEY_BYTES  (KEY_BYTES)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a run that reaches the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat, wait for it to be taken, then maybe go idle a while
  task automatic send_byte(input logic [7:0] c, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input logic burst);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], burst && i == s.len() - 1);
  endtask

  // Any byte but a line delimiter
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CH_CR || c == CH_LF) ? ~c : c;
  endfunction

  // Text-like byte, weighted toward blanks and separators
  function automatic logic [7:0] text_byte();
    unique case ($urandom_range(0, 15))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_COLON;
      3: return CH_HASH;
      4: return body_byte();
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  // Build a mostly well-formed line and end it one of several ways
  task automatic send_random_line();
    logic [7:0] body [$];
    int         klen;
    int         dlen;
    int         i;
    int         ending;
    if ($urandom_range(0, 11) == 0) begin
      // noise: raw bytes, delimiters and burst ends included
      repeat ($urandom_range(1, 12)) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
      return;
    end
    body.push_back($urandom_range(0, 9) == 0 ? body_byte() : CH_HASH);
    klen = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
    for (i = 0; i < klen; i++) body.push_back(text_byte());
    if ($urandom_range(0, 3) == 0) body.push_back(CH_SPACE);
    if ($urandom_range(0, 6) != 0) body.push_back(CH_COLON);
    dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
    for (i = 0; i < dlen; i++) body.push_back(text_byte());
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(28, 40)) body.push_back(text_byte());
    end
    repeat ($urandom_range(0, 3)) body.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    ending = $urandom_range(0, 19);
    for (i = 0; i < body.size(); i++) begin
      send_byte(body[i], ending >= 17 && i == body.size() - 1);
    end
    if (ending < 8) begin
      send_byte(CH_LF, 1'b0);
    end else if (ending < 13) begin
      send_byte(CH_CR, 1'b0);
    end else if (ending < 15) begin
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
    end else if (ending < 17) begin
      send_byte(CH_LF, 1'b1);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off, no stalls at the end
  initial begin
    int stall_left;
    bit held_off;
    stall_left = 0;
    held_off = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!held_off && beats_sent >= HOLD_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stall_left == 0 && !quiet_phase && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 18);
        end
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: each status, blank lines, extreme bytes, burst flushes
    send_text("#:x\r", 1'b0);
    send_text("#ab\n", 1'b0);
    send_text("x\n", 1'b0);
    send_text("\n", 1'b0);
    send_text(" \t\r", 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_COLON, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("#a:b\n", 1'b1);
    send_byte(CH_HASH, 1'b0);
    for (i = 0; i < 34; i++) send_byte(8'("a" + (i % 26)), 1'b0);
    send_byte(CH_LF, 1'b0);

    while (beats_sent < BEATS_TOTAL) send_random_line();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // Drain and let the block settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/aclp_pkg.sv
rtl/core/aclp_line_ram.sv
rtl/core/aclp_line_scan.sv
rtl/core/aclp_emit.sv
rtl/core/ascii_command_line_parser.sv
verif/aclp_result_checker.sv
verif/tb_ascii_command_line_parser.sv
